@@ sv/derivative_peak_detector_defines.svh @@
// Assertion macros shared by the peak detector RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DERIVATIVE_PEAK_DETECTOR_DEFINES_SVH
`define DERIVATIVE_PEAK_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked by clk and disabled during reset.
`define DPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("peak detector assertion failed");
// Next-cycle implication, clocked by clk and disabled during reset.
`define DPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("peak detector assertion failed");
`else
`define DPD_ASSERT_IMP(lbl, ante, cons)
`define DPD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ sv/dpd_pkg.sv @@
// Shared types, constants and helper functions of the peak detector.
// No dependencies; imported by every module of the block.
package dpd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int INDEX_BITS  = 16;
  localparam int COUNT_BITS  = 8;
  localparam int SLOPE_BITS  = SAMPLE_BITS + 2;
  localparam int PEAK_LIMIT  = 255;
  localparam int CFG_IDX_W   = 2;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PEAKS      = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SLOPE_BITS-1:0]  slope_t;
  typedef logic [INDEX_BITS-1:0]         idx_t;
  typedef logic [COUNT_BITS-1:0]         count_t;

  // A slope of 1.0 in doubled Q15.8.
  localparam slope_t SLOPE_ONE_X2 = slope_t'(512);
  localparam idx_t   MIN_LENGTH   = idx_t'(3);

  // One classified crossing event handed from the front end to the back end.
  typedef struct packed {
    logic qa;     // candidate at pos_a passed all signal tests
    logic qb;     // end-of-record candidate at pos_b passed all signal tests
    idx_t pos_a;
    idx_t pos_b;
    logic done;   // this sample closes the record
  } qentry_t;

  // Record length with the short-record floor applied.
  function automatic idx_t eff_len(input idx_t len);
    eff_len = (len < MIN_LENGTH) ? MIN_LENGTH : len;
  endfunction

  // Signal tests of a candidate: zero crossing of the slope, slope bound,
  // amplitude above threshold and a steep enough drop.
  function automatic logic qualify(input sample_t yi, input slope_t sa, input slope_t sb,
                                   input sample_t amp, input sample_t slth);
    logic signed [SLOPE_BITS:0] drop;
    logic signed [SLOPE_BITS:0] thr2;
    drop = (SLOPE_BITS+1)'(sa) - (SLOPE_BITS+1)'(sb);
    thr2 = $signed({{2{slth[SAMPLE_BITS-1]}}, slth, 1'b0});
    qualify = !sa[SLOPE_BITS-1] && sb[SLOPE_BITS-1] && (sa <= SLOPE_ONE_X2) &&
              (yi > amp) && (drop > thr2);
  endfunction

endpackage

@@ sv/dpd_front.sv @@
// Front end: takes samples, keeps the slope history and classifies candidates.
// Depends on dpd_pkg; pushes qentry_t events into the event queue.
module dpd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  dpd_pkg::sample_t sample,
  input  dpd_pkg::idx_t    len_eff,
  input  dpd_pkg::sample_t amp_th,
  input  dpd_pkg::sample_t slope_th,
  output logic             push,
  output dpd_pkg::qentry_t entry
);
  import dpd_pkg::*;

  sample_t older_r, older_nxt;
  sample_t prev_r, prev_nxt;
  slope_t  pslope_r, pslope_nxt;
  idx_t    idx_r, idx_nxt;

  logic signed [SAMPLE_BITS:0] d_old;
  logic signed [SAMPLE_BITS:0] d_prev;
  slope_t s_new;
  slope_t s_end;
  logic   jge2;
  logic   done;
  logic   qa;
  logic   qb;

  // Differences against the stored history.
  assign d_old  = (SAMPLE_BITS+1)'(sample) - (SAMPLE_BITS+1)'(older_r);
  assign d_prev = (SAMPLE_BITS+1)'(sample) - (SAMPLE_BITS+1)'(prev_r);
  assign s_new  = SLOPE_BITS'(d_old);
  assign s_end  = $signed({d_prev, 1'b0});

  // Record position and the two candidate tests.
  assign jge2 = (idx_r >= idx_t'(2));
  assign done = jge2 && (({1'b0, idx_r} + (INDEX_BITS+1)'(1)) >= {1'b0, len_eff});
  assign qa   = jge2 && qualify(older_r, pslope_r, s_new, amp_th, slope_th);
  assign qb   = done && qualify(prev_r, s_new, s_end, amp_th, slope_th);

  // Only events that can change the back end are queued.
  assign push        = accept && (qa || done);
  assign entry.qa    = qa;
  assign entry.qb    = qb;
  assign entry.pos_a = idx_r - idx_t'(2);
  assign entry.pos_b = idx_r - idx_t'(1);
  assign entry.done  = done;

  // History update on each sample transfer.
  always_comb begin
    older_nxt  = older_r;
    prev_nxt   = prev_r;
    pslope_nxt = pslope_r;
    idx_nxt    = idx_r;
    if (accept) begin
      if (done) begin
        older_nxt  = '0;
        prev_nxt   = '0;
        pslope_nxt = '0;
        idx_nxt    = '0;
      end else begin
        idx_nxt  = idx_r + idx_t'(1);
        prev_nxt = sample;
        if (idx_r == idx_t'(1)) begin
          pslope_nxt = s_end;
          older_nxt  = prev_r;
        end else if (jge2) begin
          pslope_nxt = s_new;
          older_nxt  = prev_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r  <= '0;
      prev_r   <= '0;
      pslope_r <= '0;
      idx_r    <= '0;
    end else begin
      older_r  <= older_nxt;
      prev_r   <= prev_nxt;
      pslope_r <= pslope_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule

@@ sv/dpd_queue.sv @@
// Short event queue between the front end and the back end.
// Depends on dpd_pkg for the entry type and the depth constants.
module dpd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dpd_pkg::qentry_t wr_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output dpd_pkg::qentry_t head
);
  import dpd_pkg::*;

`include "derivative_peak_detector_defines.svh"

  qentry_t mem [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rptr_r];

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt  = push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt  = pop ? rptr_r + QPTR_W'(1) : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wr_entry;
    end
  end

  `DPD_ASSERT_IMP(a_no_push_full, push, !full)
  `DPD_ASSERT_IMP(a_no_pop_empty, pop, head_valid)
  `DPD_ASSERT_NXT(a_count_grows, push && !pop, count_r == $past(count_r) + QCNT_W'(1))

endmodule

@@ sv/dpd_back.sv @@
// Back end: applies list capacity and spacing rules and drives the result register.
// Depends on dpd_pkg; reads events from the event queue.
module dpd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  dpd_pkg::qentry_t head,
  output logic             pop,
  input  dpd_pkg::idx_t    len_eff,
  input  dpd_pkg::count_t  cap,
  output logic             out_valid,
  input  logic             out_stall,
  output dpd_pkg::idx_t    out_peak_position,
  output dpd_pkg::count_t  out_peak_count,
  output logic             out_overflow,
  output logic             out_record_done,
  output logic             out_run_last
);
  import dpd_pkg::*;

`include "derivative_peak_detector_defines.svh"

  localparam logic [1:0] PH_A   = 2'd0;
  localparam logic [1:0] PH_B   = 2'd1;
  localparam logic [1:0] PH_SUM = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [1:0] cur_ph;
  count_t     kept_r, kept_nxt;
  idx_t       last_r, last_nxt;
  logic       stopped_r, stopped_nxt;
  logic       valid_r, valid_nxt;
  idx_t       pos_r;
  count_t     cnt_r;
  logic       ovf_r;
  logic       done_r;
  logic       run_last_r;

  logic       out_free;
  logic       step;
  logic       test_q;
  idx_t       test_pos;
  idx_t       pos_gap;
  logic [INDEX_BITS+4:0] dist20;
  logic       take;
  logic       full_hit;
  logic       near;
  logic       keep;
  logic       is_sum;
  logic       emit;

  // Phase actually worked on; an unqualified first candidate is skipped.
  always_comb begin
    cur_ph = phase_r;
    if (phase_r == PH_A && !head.qa) begin
      cur_ph = head.qb ? PH_B : PH_SUM;
    end
  end

  assign out_free = !valid_r || !out_stall;
  assign step     = head_valid && out_free;
  assign is_sum   = (cur_ph == PH_SUM);
  assign test_q   = (cur_ph == PH_A) ? head.qa : ((cur_ph == PH_B) ? head.qb : 1'b0);
  assign test_pos = (cur_ph == PH_A) ? head.pos_a : head.pos_b;

  // Capacity and minimum spacing against the last kept peak.
  assign pos_gap  = test_pos - last_r;
  assign dist20   = {1'b0, pos_gap, 4'b0} + {3'b0, pos_gap, 2'b0};
  assign take     = !stopped_r && test_q;
  assign full_hit = take && (kept_r >= cap);
  assign near     = (kept_r != '0) && (test_pos >= last_r) &&
                    (dist20 < (INDEX_BITS+5)'(len_eff));
  assign keep     = take && !full_hit && !near;
  assign emit     = is_sum || keep;

  // Event sequencing and list state.
  always_comb begin
    phase_nxt   = phase_r;
    kept_nxt    = kept_r;
    last_nxt    = last_r;
    stopped_nxt = stopped_r;
    pop         = 1'b0;
    if (step) begin
      if (is_sum) begin
        kept_nxt    = '0;
        last_nxt    = '0;
        stopped_nxt = 1'b0;
        phase_nxt   = PH_A;
        pop         = 1'b1;
      end else begin
        if (full_hit) begin
          stopped_nxt = 1'b1;
        end
        if (keep) begin
          last_nxt = test_pos;
          kept_nxt = kept_r + count_t'(1);
        end
        if (cur_ph == PH_A) begin
          if (!head.done) begin
            pop = 1'b1;
          end else begin
            phase_nxt = head.qb ? PH_B : PH_SUM;
          end
        end else begin
          phase_nxt = PH_SUM;
        end
      end
    end
  end

  // Result register valid.
  always_comb begin
    valid_nxt = valid_r;
    if (step && emit) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_A;
      kept_r    <= '0;
      last_r    <= '0;
      stopped_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      kept_r    <= kept_nxt;
      last_r    <= last_nxt;
      stopped_r <= stopped_nxt;
      valid_r   <= valid_nxt;
    end
  end

  // Result payload, loaded on each emitted result.
  always_ff @(posedge clk) begin
    if (step && emit) begin
      pos_r      <= is_sum ? '0 : test_pos;
      cnt_r      <= is_sum ? kept_r : kept_r + count_t'(1);
      ovf_r      <= is_sum && stopped_r;
      done_r     <= is_sum;
      run_last_r <= is_sum || !head.done;
    end
  end

  assign out_valid         = valid_r;
  assign out_peak_position = pos_r;
  assign out_peak_count    = cnt_r;
  assign out_overflow      = ovf_r;
  assign out_record_done   = done_r;
  assign out_run_last      = run_last_r;

  `DPD_ASSERT_NXT(a_sum_clears, step && is_sum, kept_r == '0 && !stopped_r)
  `DPD_ASSERT_IMP(a_keep_not_stopped, step && keep, !stopped_r && kept_r < cap)
  `DPD_ASSERT_IMP(a_peak_count_nonzero, valid_r && !done_r, cnt_r != '0)

endmodule

@@ sv/derivative_peak_detector.sv @@
// Top level of the derivative zero-crossing peak detector.
// Depends on dpd_pkg, dpd_front, dpd_queue and dpd_back.
//
// Usage:
//   Input channel (in_valid / in_stall / in_sample) carries one signed Q15.8
//   sample per transfer; record_length samples form one record.
//   Result channel (out_valid / out_stall / out_*) carries one peak per
//   transfer and one summary item (out_record_done = 1) closing each record.
//   out_run_last marks the last result caused by one sample.
//   Configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) is
//   always ready; write it only while the block is idle.
// Timing:
//   A sample is taken every cycle while the four-entry event queue has room.
//   The back end emits at most one result per cycle while the result register
//   is free, so a record end can take phases A, B and SUM in turn there, and the
//   result register is the limit when peaks come closely spaced.
// Reset and stall:
//   Synchronous reset clears all record state and loads the register
//   defaults. A stalled result holds; the queue then fills and in_stall rises.
module derivative_peak_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  dpd_pkg::sample_t                 in_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output dpd_pkg::idx_t                    out_peak_position,
  output dpd_pkg::count_t                  out_peak_count,
  output logic                             out_overflow,
  output logic                             out_record_done,
  output logic                             out_run_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpd_pkg::SAMPLE_BITS-1:0]  cfg_data
);
  import dpd_pkg::*;

  idx_t    record_length_r;
  sample_t amp_threshold_r;
  sample_t slope_threshold_r;
  count_t  max_peaks_r;

  idx_t    len_eff;
  count_t  cap;
  logic    in_accept;
  logic    push;
  logic    pop;
  logic    full;
  logic    head_valid;
  qentry_t wr_entry;
  qentry_t head;

  // Configuration registers, written on each cfg transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      record_length_r   <= idx_t'(1024);
      amp_threshold_r   <= '0;
      slope_threshold_r <= '0;
      max_peaks_r       <= count_t'(16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RECORD_LENGTH:   record_length_r   <= cfg_data[INDEX_BITS-1:0];
        REG_AMP_THRESHOLD:   amp_threshold_r   <= cfg_data;
        REG_SLOPE_THRESHOLD: slope_threshold_r <= cfg_data;
        REG_MAX_PEAKS:       max_peaks_r       <= cfg_data[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Derived limits.
  assign len_eff = eff_len(record_length_r);
  assign cap     = (max_peaks_r < count_t'(PEAK_LIMIT)) ? max_peaks_r : count_t'(PEAK_LIMIT);

  assign in_stall  = full;
  assign in_accept = in_valid && !in_stall;

  dpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .sample   (in_sample),
    .len_eff  (len_eff),
    .amp_th   (amp_threshold_r),
    .slope_th (slope_threshold_r),
    .push     (push),
    .entry    (wr_entry)
  );

  dpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wr_entry   (wr_entry),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  dpd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop),
    .len_eff           (len_eff),
    .cap               (cap),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_peak_position (out_peak_position),
    .out_peak_count    (out_peak_count),
    .out_overflow      (out_overflow),
    .out_record_done   (out_record_done),
    .out_run_last      (out_run_last)
  );

endmodule

@@ tb/peak_report_checker.sv @@
// Checker for the derivative peak detector: predicts the peak and summary items
// and compares them with what the block sends. Depends on dpd_pkg.
`timescale 1ns / 1ps

module peak_report_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  dpd_pkg::sample_t                in_sample,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  dpd_pkg::idx_t                   out_peak_position,
  input  dpd_pkg::count_t                 out_peak_count,
  input  logic                            out_overflow,
  input  logic                            out_record_done,
  input  logic                            out_run_last,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpd_pkg::SAMPLE_BITS-1:0] cfg_data,
  output int                              mismatch_total,
  output int                              reports_pending
);
  import dpd_pkg::*;

  typedef struct packed {
    idx_t   position;
    count_t count;
    logic   overflow;
    logic   done;
    logic   last;
  } report_t;

  // Register copies.
  idx_t    rec_len;
  sample_t amp_thr;
  sample_t slope_thr;
  count_t  max_pk;

  // Record state: the two samples before the newest one, the doubled slope
  // at the older of them, and the peak list bookkeeping.
  sample_t y_older;
  sample_t y_prev;
  slope_t  slope_prev;
  idx_t    idx;
  count_t  kept;
  idx_t    last_peak;
  logic    stopped;

  report_t reports_due[$];
  report_t step_reports[$];
  int      mismatches = 0;

  task automatic clear_record();
    y_older    = '0;
    y_prev     = '0;
    slope_prev = '0;
    idx        = '0;
    kept       = '0;
    last_peak  = '0;
    stopped    = 1'b0;
  endtask

  // Decides one candidate position from its sample and the doubled slopes on
  // both sides of the crossing; a kept peak is appended to this step's results.
  task automatic take_candidate(input idx_t pos, input sample_t yi, input slope_t sa,
                                input slope_t sb);
    int      cap;
    int      span;
    report_t r;
    cap  = (int'(max_pk) < PEAK_LIMIT) ? int'(max_pk) : PEAK_LIMIT;
    span = (int'(rec_len) < 3) ? 3 : int'(rec_len);
    if (!stopped && sa >= 0 && sb < 0 && sa <= SLOPE_ONE_X2 && yi > amp_thr &&
        (int'(sa) - int'(sb)) > 2 * int'(slope_thr)) begin
      if (int'(kept) >= cap) begin
        // A full list ends the search, even for a peak that would be dropped.
        stopped = 1'b1;
      end else if (!(kept != 0 && pos >= last_peak &&
                     20 * (int'(pos) - int'(last_peak)) < span)) begin
        last_peak  = pos;
        kept       = kept + 1'b1;
        r.position = pos;
        r.count    = kept;
        r.overflow = 1'b0;
        r.done     = 1'b0;
        r.last     = 1'b0;
        step_reports.push_back(r);
      end
    end
  endtask

  // Advances the record by one sample and queues the results it causes.
  task automatic track_sample(input sample_t y);
    int      span;
    slope_t  s_new;
    slope_t  s_end;
    report_t r;
    span = (int'(rec_len) < 3) ? 3 : int'(rec_len);
    step_reports.delete();
    if (idx == 0) begin
      y_prev = y;
    end else if (idx == 1) begin
      slope_prev = slope_t'(2 * (int'(y) - int'(y_prev)));
      y_older    = y_prev;
      y_prev     = y;
    end else begin
      s_new = slope_t'(int'(y) - int'(y_older));
      take_candidate(idx - 16'd2, y_older, slope_prev, s_new);
      slope_prev = s_new;
      y_older    = y_prev;
      y_prev     = y;
    end
    // The record closes here: test the next-to-last position with the
    // backward difference, then emit the summary.
    if (idx >= 2 && int'(idx) + 1 >= span) begin
      s_end = slope_t'(2 * (int'(y) - int'(y_older)));
      take_candidate(idx - 16'd1, y_older, slope_prev, s_end);
      r.position = '0;
      r.count    = kept;
      r.overflow = stopped;
      r.done     = 1'b1;
      r.last     = 1'b0;
      step_reports.push_back(r);
      clear_record();
    end else begin
      idx = idx + 1'b1;
    end
    foreach (step_reports[k]) begin
      r      = step_reports[k];
      r.last = (k == step_reports.size() - 1);
      reports_due.push_back(r);
    end
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin : watch
    report_t want;
    if (!rst_n) begin
      rec_len   = idx_t'(1024);
      amp_thr   = '0;
      slope_thr = '0;
      max_pk    = count_t'(16);
      clear_record();
      reports_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RECORD_LENGTH:   rec_len   = idx_t'(cfg_data);
          REG_AMP_THRESHOLD:   amp_thr   = cfg_data;
          REG_SLOPE_THRESHOLD: slope_thr = cfg_data;
          REG_MAX_PEAKS:       max_pk    = count_t'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        track_sample(in_sample);
      end
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          $error("unexpected result: position %0d, count %0d, record_done %0b",
                 out_peak_position, out_peak_count, out_record_done);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          compare_field("peak_position", want.position, out_peak_position);
          compare_field("peak_count", want.count, out_peak_count);
          compare_field("overflow", want.overflow, out_overflow);
          compare_field("record_done", want.done, out_record_done);
          compare_field("run_last", want.last, out_run_last);
        end
      end
    end
    mismatch_total  <= mismatches;
    reports_pending <= reports_due.size();
  end

endmodule

@@ tb/tb_derivative_peak_detector.sv @@
// Top of the peak detector testbench: clock, reset, register setup, sample
// stimulus and the verdict. Depends on dpd_pkg, the block and peak_report_checker.
`timescale 1ns / 1ps

module tb_derivative_peak_detector;
  import dpd_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_SAMPLES = 34;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  sample_t                in_sample = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  idx_t                   out_peak_position;
  count_t                 out_peak_count;
  logic                   out_overflow;
  logic                   out_record_done;
  logic                   out_run_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [SAMPLE_BITS-1:0] cfg_data  = '0;

  int          mismatch_total;
  int          reports_pending;
  int unsigned cycle_count = 0;
  int          level = 0;

  derivative_peak_detector uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_peak_position (out_peak_position),
    .out_peak_count    (out_peak_count),
    .out_overflow      (out_overflow),
    .out_record_done   (out_record_done),
    .out_run_last      (out_run_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  peak_report_checker checker_inst (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_peak_position (out_peak_position),
    .out_peak_count    (out_peak_count),
    .out_overflow      (out_overflow),
    .out_record_done   (out_record_done),
    .out_run_last      (out_run_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_total    (mismatch_total),
    .reports_pending   (reports_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver cycles through free flow, light and heavy random stalls,
  // and a fixed duty pattern.
  always @(posedge clk) begin
    case ((cycle_count / 256) % 4)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((cycle_count % 5) < 2);
    endcase
  end

  // One sample transfer; returns at the edge that accepts it.
  task automatic push_sample(input sample_t value);
    in_valid  <= 1'b1;
    in_sample <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold the sender until every predicted result has been transferred.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] which,
                           input logic [SAMPLE_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic set_config(input int len, input int amp, input int slth, input int maxp);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_RECORD_LENGTH, SAMPLE_BITS'(len));
    write_reg(REG_AMP_THRESHOLD, SAMPLE_BITS'(amp));
    write_reg(REG_SLOPE_THRESHOLD, SAMPLE_BITS'(slth));
    write_reg(REG_MAX_PEAKS, SAMPLE_BITS'(maxp));
    cfg_valid <= 1'b0;
  endtask

  // Mostly a random walk, which gives slope crossings of all kinds; one sample
  // in twenty is full-range noise.
  function automatic sample_t draw_sample(input int shape);
    int step;
    if ($urandom_range(0, 19) == 0) begin
      return sample_t'($urandom());
    end
    step  = (shape == 1) ? 40 : 150;
    level = level + $urandom_range(0, 2 * step) - step;
    if (level > 8388607) level = 8388607;
    if (level < -8388608) level = -8388608;
    return sample_t'(level);
  endfunction

  task automatic send_random_run(input int count, input int shape);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && sent < count) begin
        push_sample(draw_sample(shape));
        sent++;
        burst--;
      end
      if ($urandom_range(0, 19) == 0) begin
        wait_drained();
      end else if ($urandom_range(0, 2) != 0) begin
        idle_gap($urandom_range(1, 6));
      end
    end
  endtask

  initial begin
    int len;
    int amp;
    int slth;
    int maxp;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Shortest record with the lowest thresholds: a simple peak, then the
    // sample extremes, one of which breaks the slope bound.
    set_config(0, -8388608, -8388608, 255);
    push_sample(0);
    push_sample(100);
    push_sample(0);
    push_sample(8388607);
    push_sample(-8388608);
    push_sample(8388607);
    push_sample(-8388608);
    push_sample(8388607);
    push_sample(-8388608);

    // Two peaks two apart in a long record: the second is too close. The
    // record is then closed by shortening it mid-record.
    set_config(60, 0, 0, 2);
    push_sample(0);
    push_sample(10);
    push_sample(0);
    push_sample(5);
    push_sample(0);
    push_sample(0);
    set_config(3, 0, 0, 2);
    push_sample(0);

    // Zero capacity: the first qualifying peak stops the search.
    set_config(3, 0, 0, 0);
    push_sample(0);
    push_sample(100);
    push_sample(0);

    // A full list stops the search at a peak that would have been too close.
    set_config(60, 0, 0, 1);
    push_sample(0);
    push_sample(10);
    push_sample(0);
    push_sample(5);
    push_sample(0);
    push_sample(0);
    set_config(3, 0, 0, 1);
    push_sample(0);

    // Random phases; some take register extremes, most take small records
    // and thresholds near the signal level.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       len = 65535;
        1:       len = 3;
        2:       len = 4;
        default: len = $urandom_range(5, 60);
      endcase
      case (p)
        3:       amp = 8388607;
        4:       amp = -8388608;
        default: amp = $urandom_range(0, 600) - 300;
      endcase
      case (p)
        5:       slth = 8388607;
        6:       slth = -8388608;
        default: slth = $urandom_range(0, 100) - 50;
      endcase
      case (p)
        2:       maxp = 0;
        7:       maxp = 255;
        default: maxp = $urandom_range(1, 4);
      endcase
      set_config(len, amp, slth, maxp);
      level = 0;
      send_random_run(PHASE_SAMPLES, p % 3);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_total == 0 && reports_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
